// File: hw/rtl/imu_zoc_pkg.sv
// Package for the IMU zero-offset calibrator: widths, defaults and the item types.
// Shared by every module of the block; depends on nothing.
package imu_zoc_pkg;

   // Sample and accumulator widths
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 24;
   localparam int CNT_W    = 8;
   localparam int NUM_GYRO = 3;
   localparam int NUM_ACAL = 2;

   // Defaults for the top-level parameters
   localparam int DEF_CAL_SAMPLES    = 200;
   localparam int DEF_WARMUP_SAMPLES = 200;

   // Saturation limits
   localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

   // Reciprocal divider: |sum| < 2**23, divisor < 2**8, so a 31-bit shift is exact
   localparam int MAG_W     = 23;
   localparam int RECIP_W   = 32;
   localparam int DIV_SHIFT = 31;
   localparam int PROD_W    = MAG_W + RECIP_W;
   localparam int QUOT_W    = 17;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x_raw;
      logic signed [SAMPLE_W-1:0] accel_y_raw;
      logic signed [SAMPLE_W-1:0] accel_z_raw;
      logic signed [SAMPLE_W-1:0] gyro_x_raw;
      logic signed [SAMPLE_W-1:0] gyro_y_raw;
      logic signed [SAMPLE_W-1:0] gyro_z_raw;
      logic                       start_accel_cal;
      logic                       start_gyro_cal;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_z;
      logic signed [SAMPLE_W-1:0] gyro_x;
      logic signed [SAMPLE_W-1:0] gyro_y;
      logic signed [SAMPLE_W-1:0] gyro_z;
      logic                       accel_cal_valid;
      logic                       gyro_cal_valid;
   } rsp_item_type;

   // Stored offsets; accel Z offset is always zero and is not kept
   typedef struct packed {
      logic [NUM_GYRO-1:0][SAMPLE_W-1:0] gyro;
      logic [NUM_ACAL-1:0][SAMPLE_W-1:0] accel;
   } offset_set_type;

   // Divide request: one pulse with the finished sums
   typedef struct packed {
      logic                           go;
      logic [NUM_GYRO-1:0][SUM_W-1:0] sum;
   } div_req_type;

   // Divide result: one pulse with the quotients
   typedef struct packed {
      logic                              valid;
      logic [NUM_GYRO-1:0][SAMPLE_W-1:0] quot;
   } div_rsp_type;

   // Calibration status seen by the pipeline
   typedef struct packed {
      logic busy;
      logic accel_done;
      logic gyro_done;
   } cal_status_type;

endpackage

// File: hw/rtl/imu_zoc_corrector.sv
// One lane of offset removal: raw word minus offset, saturated to 16 bits.
// Uses imu_zoc_pkg for widths and saturation limits.
module imu_zoc_corrector (
   input  logic [imu_zoc_pkg::SAMPLE_W-1:0] raw,
   input  logic [imu_zoc_pkg::SAMPLE_W-1:0] offset,
   output logic [imu_zoc_pkg::SAMPLE_W-1:0] corr
);

   logic [imu_zoc_pkg::SAMPLE_W:0] diff;

   // Subtract with one guard bit, then clamp on overflow
   always_comb begin
      diff = {raw[imu_zoc_pkg::SAMPLE_W-1], raw}
           - {offset[imu_zoc_pkg::SAMPLE_W-1], offset};
      if (diff[imu_zoc_pkg::SAMPLE_W] != diff[imu_zoc_pkg::SAMPLE_W-1]) begin
         corr = diff[imu_zoc_pkg::SAMPLE_W] ? imu_zoc_pkg::SAT_MIN : imu_zoc_pkg::SAT_MAX;
      end else begin
         corr = diff[imu_zoc_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

// File: hw/rtl/imu_zoc_divider.sv
// Signed divide of the calibration sums by CAL_SAMPLES, truncating toward zero, by
// reciprocal multiply; the quotient magnitudes are registered. Uses imu_zoc_pkg types and widths.
module imu_zoc_divider #(
   parameter int CAL_SAMPLES = imu_zoc_pkg::DEF_CAL_SAMPLES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  imu_zoc_pkg::div_req_type div_req,
   output imu_zoc_pkg::div_rsp_type div_rsp
);

   localparam longint unsigned RECIP_L =
      ((64'd1 << imu_zoc_pkg::DIV_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
   localparam logic [imu_zoc_pkg::RECIP_W-1:0] RECIP = imu_zoc_pkg::RECIP_W'(RECIP_L);

   logic [imu_zoc_pkg::NUM_GYRO-1:0][imu_zoc_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [imu_zoc_pkg::NUM_GYRO-1:0]                          neg_ff, neg_in;
   logic                                                      valid_ff;
   logic [imu_zoc_pkg::SUM_W-1:0]                             mag_full;
   logic [imu_zoc_pkg::PROD_W-1:0]                            prod;

   // Take magnitudes and multiply by the reciprocal
   always_comb begin
      mag_full = '0;
      prod     = '0;
      for (int i = 0; i < imu_zoc_pkg::NUM_GYRO; i++) begin
         neg_in[i] = div_req.sum[i][imu_zoc_pkg::SUM_W-1];
         mag_full  = neg_in[i] ? -div_req.sum[i] : div_req.sum[i];
         prod      = imu_zoc_pkg::PROD_W'(mag_full[imu_zoc_pkg::MAG_W-1:0])
                   * imu_zoc_pkg::PROD_W'(RECIP);
         quot_in[i] = prod[imu_zoc_pkg::DIV_SHIFT +: imu_zoc_pkg::QUOT_W];
      end
   end

   // Hold the quotient magnitudes for the sign stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= div_req.go;
      end
      quot_ff <= quot_in;
      neg_ff  <= neg_in;
   end

   // Restore the sign
   always_comb begin
      div_rsp.valid = valid_ff;
      for (int i = 0; i < imu_zoc_pkg::NUM_GYRO; i++) begin
         div_rsp.quot[i] = neg_ff[i]
            ? imu_zoc_pkg::SAMPLE_W'(-quot_ff[i])
            : imu_zoc_pkg::SAMPLE_W'(quot_ff[i]);
      end
   end

endmodule

// File: hw/rtl/imu_zoc_cal_ctrl.sv
// Calibration sequencer: warm-up and sample counters, running sums, done flags
// and the stored offsets. Uses imu_zoc_pkg types; drives imu_zoc_divider.
module imu_zoc_cal_ctrl #(
   parameter int CAL_SAMPLES    = imu_zoc_pkg::DEF_CAL_SAMPLES,
   parameter int WARMUP_SAMPLES = imu_zoc_pkg::DEF_WARMUP_SAMPLES
) (
   input  logic                                                        clock,
   input  logic                                                        reset,
   input  logic                                                        fire,
   input  logic                                                        start_accel,
   input  logic                                                        start_gyro,
   input  logic [imu_zoc_pkg::NUM_ACAL-1:0][imu_zoc_pkg::SAMPLE_W-1:0] acc_corr,
   input  logic [imu_zoc_pkg::NUM_GYRO-1:0][imu_zoc_pkg::SAMPLE_W-1:0] gyr_corr,
   input  imu_zoc_pkg::div_rsp_type                                    div_rsp,
   output imu_zoc_pkg::div_req_type                                    div_req,
   output imu_zoc_pkg::offset_set_type                                 offsets,
   output imu_zoc_pkg::cal_status_type                                 status
);

   localparam imu_zoc_pkg::cnt_type CAL_N  = imu_zoc_pkg::cnt_type'(CAL_SAMPLES);
   localparam imu_zoc_pkg::cnt_type WARM_N = imu_zoc_pkg::cnt_type'(WARMUP_SAMPLES);
   localparam imu_zoc_pkg::cnt_type CNT_ONE = imu_zoc_pkg::cnt_type'(1);

   imu_zoc_pkg::offset_set_type                                 off_ff, off_in;
   logic [imu_zoc_pkg::NUM_GYRO-1:0][imu_zoc_pkg::SUM_W-1:0]    gsum_ff, gsum_in;
   logic [imu_zoc_pkg::NUM_ACAL-1:0][imu_zoc_pkg::SUM_W-1:0]    asum_ff, asum_in;
   imu_zoc_pkg::cnt_type warm_ff, warm_in, gcnt_ff, gcnt_in, acnt_ff, acnt_in;
   logic gdone_ff, gdone_in, adone_ff, adone_in;
   logic div_go_ff, div_go_in, div_gyro_ff, div_gyro_in;
   logic gdone_eff, adone_eff, skip_accel;

   // Advance the calibration on each processed item, store quotients on return
   always_comb begin
      off_in      = off_ff;
      gsum_in     = gsum_ff;
      asum_in     = asum_ff;
      warm_in     = warm_ff;
      gcnt_in     = gcnt_ff;
      acnt_in     = acnt_ff;
      gdone_in    = gdone_ff;
      adone_in    = adone_ff;
      div_go_in   = 1'b0;
      div_gyro_in = div_gyro_ff;
      skip_accel  = 1'b0;
      gdone_eff   = gdone_ff & ~start_gyro;
      adone_eff   = adone_ff & ~start_accel;

      if (fire) begin
         gdone_in = gdone_eff;
         adone_in = adone_eff;

         // Gyro: warm-up, clearing sample, then summing
         if (!gdone_eff) begin
            if (warm_ff < WARM_N) begin
               warm_in = warm_ff + CNT_ONE;
            end else if (gcnt_ff == '0) begin
               gsum_in    = '0;
               off_in.gyro = '0;
               gcnt_in    = CNT_ONE;
               skip_accel = 1'b1;
            end else begin
               for (int i = 0; i < imu_zoc_pkg::NUM_GYRO; i++) begin
                  gsum_in[i] = gsum_ff[i]
                     + {{(imu_zoc_pkg::SUM_W-imu_zoc_pkg::SAMPLE_W)
                         {gyr_corr[i][imu_zoc_pkg::SAMPLE_W-1]}}, gyr_corr[i]};
               end
               if (gcnt_ff == CAL_N) begin
                  gcnt_in     = '0;
                  gdone_in    = 1'b1;
                  skip_accel  = 1'b1;
                  div_go_in   = 1'b1;
                  div_gyro_in = 1'b1;
               end else begin
                  gcnt_in = gcnt_ff + CNT_ONE;
               end
            end
         end

         // Accel: clearing sample, then summing X and Y
         if (!skip_accel && !adone_eff) begin
            if (acnt_ff == '0) begin
               asum_in      = '0;
               off_in.accel = '0;
               acnt_in      = CNT_ONE;
            end else begin
               for (int i = 0; i < imu_zoc_pkg::NUM_ACAL; i++) begin
                  asum_in[i] = asum_ff[i]
                     + {{(imu_zoc_pkg::SUM_W-imu_zoc_pkg::SAMPLE_W)
                         {acc_corr[i][imu_zoc_pkg::SAMPLE_W-1]}}, acc_corr[i]};
               end
               if (acnt_ff == CAL_N) begin
                  acnt_in     = '0;
                  adone_in    = 1'b1;
                  div_go_in   = 1'b1;
                  div_gyro_in = 1'b0;
               end else begin
                  acnt_in = acnt_ff + CNT_ONE;
               end
            end
         end
      end

      // Load the finished offsets
      if (div_rsp.valid) begin
         if (div_gyro_ff) begin
            off_in.gyro = div_rsp.quot;
         end else begin
            for (int i = 0; i < imu_zoc_pkg::NUM_ACAL; i++) begin
               off_in.accel[i] = div_rsp.quot[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff      <= '0;
         warm_ff     <= '0;
         gcnt_ff     <= '0;
         acnt_ff     <= '0;
         gdone_ff    <= 1'b0;
         adone_ff    <= 1'b0;
         div_go_ff   <= 1'b0;
         div_gyro_ff <= 1'b0;
      end else begin
         off_ff      <= off_in;
         warm_ff     <= warm_in;
         gcnt_ff     <= gcnt_in;
         acnt_ff     <= acnt_in;
         gdone_ff    <= gdone_in;
         adone_ff    <= adone_in;
         div_go_ff   <= div_go_in;
         div_gyro_ff <= div_gyro_in;
      end
      gsum_ff <= gsum_in;
      asum_ff <= asum_in;
   end

   // Hand the finished sums to the divider
   always_comb begin
      div_req.go = div_go_ff;
      if (div_gyro_ff) begin
         div_req.sum = gsum_ff;
      end else begin
         div_req.sum = '0;
         for (int i = 0; i < imu_zoc_pkg::NUM_ACAL; i++) begin
            div_req.sum[i] = asum_ff[i];
         end
      end
   end

   assign offsets           = off_ff;
   assign status.busy       = div_go_ff | div_rsp.valid;
   assign status.accel_done = adone_in;
   assign status.gyro_done  = gdone_in;

endmodule

// File: hw/rtl/imu_zero_offset_calibrator_unit.sv
// IMU zero-offset calibrator: an accepted item is held in the input register and, once
// processed, in the result register; it waits while the result is stalled or the
// divider is busy. Throughput 1 item per cycle unless so stalled; after the item that
// finishes a calibration, no item is processed while the reciprocal divider sets the
// offsets. Synchronous active-high reset clears the counters and offsets and leaves
// accel and gyro calibration pending; each calibration's first sample clears its sums.
module imu_zero_offset_calibrator_unit #(
   parameter int CAL_SAMPLES    = imu_zoc_pkg::DEF_CAL_SAMPLES,
   parameter int WARMUP_SAMPLES = imu_zoc_pkg::DEF_WARMUP_SAMPLES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  imu_zoc_pkg::req_item_type req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output imu_zoc_pkg::rsp_item_type rsp_item
);

   imu_zoc_pkg::req_item_type   in_item_ff;
   logic                        in_valid_ff;
   imu_zoc_pkg::rsp_item_type   rsp_item_ff, rsp_item_in;
   logic                        rsp_valid_ff;
   logic                        out_free, fire, in_take;
   imu_zoc_pkg::offset_set_type offsets;
   imu_zoc_pkg::div_req_type    div_req;
   imu_zoc_pkg::div_rsp_type    div_rsp;
   imu_zoc_pkg::cal_status_type status;
   logic [imu_zoc_pkg::NUM_GYRO-1:0][imu_zoc_pkg::SAMPLE_W-1:0] gyr_raw, gyr_corr;
   logic [imu_zoc_pkg::NUM_ACAL-1:0][imu_zoc_pkg::SAMPLE_W-1:0] acc_raw, acc_corr;

   // Handshake: process a held item when the result register is free and the divider idle
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign fire      = in_valid_ff & out_free & ~status.busy;
   assign in_take   = ~in_valid_ff | fire;
   assign req_stall = ~in_take;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_take) begin
         in_valid_ff <= req_valid;
      end
      if (in_take && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   assign gyr_raw[0] = in_item_ff.gyro_x_raw;
   assign gyr_raw[1] = in_item_ff.gyro_y_raw;
   assign gyr_raw[2] = in_item_ff.gyro_z_raw;
   assign acc_raw[0] = in_item_ff.accel_x_raw;
   assign acc_raw[1] = in_item_ff.accel_y_raw;

   // Offset removal lanes
   for (genvar g = 0; g < imu_zoc_pkg::NUM_GYRO; g++) begin : g_gyro
      imu_zoc_corrector u_corr (
         .raw    (gyr_raw[g]),
         .offset (offsets.gyro[g]),
         .corr   (gyr_corr[g])
      );
   end
   for (genvar a = 0; a < imu_zoc_pkg::NUM_ACAL; a++) begin : g_accel
      imu_zoc_corrector u_corr (
         .raw    (acc_raw[a]),
         .offset (offsets.accel[a]),
         .corr   (acc_corr[a])
      );
   end

   imu_zoc_cal_ctrl #(
      .CAL_SAMPLES    (CAL_SAMPLES),
      .WARMUP_SAMPLES (WARMUP_SAMPLES)
   ) u_cal_ctrl (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .start_accel (in_item_ff.start_accel_cal),
      .start_gyro  (in_item_ff.start_gyro_cal),
      .acc_corr    (acc_corr),
      .gyr_corr    (gyr_corr),
      .div_rsp     (div_rsp),
      .div_req     (div_req),
      .offsets     (offsets),
      .status      (status)
   );

   imu_zoc_divider #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Build the result item; accel Z has no offset
   always_comb begin
      rsp_item_in.accel_x         = acc_corr[0];
      rsp_item_in.accel_y         = acc_corr[1];
      rsp_item_in.accel_z         = in_item_ff.accel_z_raw;
      rsp_item_in.gyro_x          = gyr_corr[0];
      rsp_item_in.gyro_y          = gyr_corr[1];
      rsp_item_in.gyro_z          = gyr_corr[2];
      rsp_item_in.accel_cal_valid = status.accel_done;
      rsp_item_in.gyro_cal_valid  = status.gyro_done;
   end

   // Result register: load on process, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
